FILE: src/tss_pkg.sv
// Shared types, constants and the segment encoder for the temperature
// seven-segment scan block. No dependencies.
package tss_pkg;

	localparam int DIGITS = 4;
	localparam int SEL_W = DIGITS;
	localparam int IDX_W = $clog2(DIGITS);
	localparam int SAMPLE_W = 10;
	localparam int INTERVAL_W = 16;

	localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd250;
	localparam logic [IDX_W-1:0] DP_DIGIT = 2'd1;
	localparam logic [15:0] MAX_VALUE = 16'd9999;
	localparam logic [SEL_W-1:0] SEL_RESET = 4'b0001;

	typedef logic [3:0] digit_t;
	typedef digit_t [DIGITS-1:0] digit_vec_t;

	// index 0 is the thousands digit
	localparam digit_vec_t RESET_DIGITS = {4'd0, 4'd0, 4'd5, 4'd2};
	localparam digit_vec_t MAX_DIGITS = {4'd9, 4'd9, 4'd9, 4'd9};

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                conv;
		logic [SEL_W-1:0]    select;
	} stage_t;

	// segments g..a in bits 6..0
	function automatic logic [6:0] seg_encode(input digit_t d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7C;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h67;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

FILE: src/tss_scan_ctrl.sv
// Scan control: digit select rotation, conversion countdown, interval
// register and the input stage register. Uses tss_pkg.
module tss_scan_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [tss_pkg::INTERVAL_W-1:0]     cfg_write_data,
	input  logic                                sample_valid,
	input  logic [tss_pkg::SAMPLE_W-1:0]       adc_sample,
	output logic                                sample_stall,
	input  logic                                take,
	output logic                                valid_s1,
	output tss_pkg::stage_t                     stage_s1
);

	logic [tss_pkg::INTERVAL_W-1:0] interval_q;
	logic [tss_pkg::INTERVAL_W-1:0] cnt_q;
	logic [tss_pkg::SEL_W-1:0]      sel_q;
	logic [tss_pkg::SEL_W-1:0]      sel_next;
	logic                           expire;
	logic                           accept;

	assign sample_stall = valid_s1 && !take;
	assign accept = sample_valid && !sample_stall;
	assign sel_next = {sel_q[tss_pkg::SEL_W-2:0], sel_q[tss_pkg::SEL_W-1]};
	assign expire = (cnt_q <= 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= tss_pkg::RESET_INTERVAL;
		end else if (cfg_write_en) begin
			interval_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= tss_pkg::RESET_INTERVAL;
			sel_q <= tss_pkg::SEL_RESET;
		end else if (accept) begin
			sel_q <= sel_next;
			if (expire) begin
				cnt_q <= interval_q;
			end else begin
				cnt_q <= cnt_q - 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.sample <= adc_sample;
			stage_s1.conv   <= expire;
			stage_s1.select <= sel_next;
		end
	end

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(sel_q))
		else $error("digit select not one-hot");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !expire |=> cnt_q == $past(cnt_q) - 16'd1)
		else $error("countdown did not decrement");

	a_conv_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && stage_s1.conv == $past(expire)
			&& stage_s1.select == $past(sel_next))
		else $error("input stage mismatch");

endmodule

FILE: src/tss_convert.sv
// Sample to decimal digits: floor(sample*50000/1024) split into four
// digits by constant multiplies, saturated at 9999. Uses tss_pkg.
module tss_convert (
	input  logic [tss_pkg::SAMPLE_W-1:0] sample,
	output tss_pkg::digit_vec_t          digits,
	output logic                         over
);

	// value = s*3125/64; each decimal prefix is floor(s*c/2^k) directly
	logic [21:0] p_val;
	logic [19:0] p_ten;
	logic [16:0] p_hun;
	logic [14:0] p_tho;
	logic [15:0] val;
	logic [12:0] tens_all;
	logic [8:0]  huns_all;
	logic [5:0]  thos_all;
	logic [15:0] ones_d;
	logic [12:0] tens_d;
	logic [8:0]  huns_d;

	assign p_val = 22'(sample) * 22'd3125;
	assign p_ten = 20'(sample) * 20'd625;
	assign p_hun = 17'(sample) * 17'd125;
	assign p_tho = 15'(sample) * 15'd25;

	assign val      = p_val[21:6];
	assign tens_all = p_ten[19:7];
	assign huns_all = p_hun[16:8];
	assign thos_all = p_tho[14:9];

	assign ones_d = val - 16'(tens_all) * 16'd10;
	assign tens_d = tens_all - 13'(huns_all) * 13'd10;
	assign huns_d = huns_all - 9'(thos_all) * 9'd10;

	assign over = (val > tss_pkg::MAX_VALUE);

	always_comb begin
		if (over) begin
			digits = tss_pkg::MAX_DIGITS;
		end else begin
			digits[0] = thos_all[3:0];
			digits[1] = huns_d[3:0];
			digits[2] = tens_d[3:0];
			digits[3] = ones_d[3:0];
		end
	end

endmodule

FILE: src/tss_display.sv
// Digit store, sticky over-range flag, segment encoding and the result
// register with its handshake. Uses tss_pkg.
module tss_display (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  tss_pkg::stage_t       stage_s1,
	input  tss_pkg::digit_vec_t   conv_digits,
	input  logic                  conv_over,
	output logic                  take,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            segment_port,
	output logic [5:0]            select_port,
	output logic                  over_range
);

	tss_pkg::digit_vec_t        digit_q;
	tss_pkg::digit_vec_t        digits_now;
	logic                       range_q;
	logic                       range_next;
	logic [tss_pkg::IDX_W-1:0]  idx;
	logic [6:0]                 seg7;
	logic                       dp;

	assign take = valid_s1 && (!result_valid || !result_stall);
	assign digits_now = stage_s1.conv ? conv_digits : digit_q;
	assign range_next = range_q || (stage_s1.conv && conv_over);

	always_comb begin
		case (stage_s1.select)
			4'b0001: idx = 2'd0;
			4'b0010: idx = 2'd1;
			4'b0100: idx = 2'd2;
			4'b1000: idx = 2'd3;
			default: idx = 2'd0;
		endcase
	end

	assign seg7 = tss_pkg::seg_encode(digits_now[idx]);
	assign dp = (idx == tss_pkg::DP_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= tss_pkg::RESET_DIGITS;
			range_q <= 1'b0;
		end else if (take && stage_s1.conv) begin
			digit_q <= conv_digits;
			range_q <= range_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			segment_port <= {seg7[5:0], 2'b00};
			select_port  <= {~stage_s1.select, dp, seg7[6]};
			over_range   <= range_next;
		end
	end

	a_range_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		range_q |=> range_q)
		else $error("over-range flag cleared");

	a_flag_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> result_valid && over_range == range_q)
		else $error("over_range does not follow flag");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> !take)
		else $error("result overwritten while stalled");

endmodule

FILE: src/temperature_seven_segment_scan.sv
// Four-digit multiplexed seven-segment temperature display driver. Each
// accepted word on the sample channel is one scan tick: the digit select
// rotates, and every read_interval ticks the sample becomes hundredths of
// a degree, floor(sample*50000/1024), shown as four digits with a point
// after digit 1. Values over 9999 show 9999 and set over_range until
// reset. One result word per sample word, one word per clock while result_stall
// stays low; each word passes the input stage, then the result register.
module temperature_seven_segment_scan (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [9:0]  adc_sample,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  segment_port,
	output logic [5:0]  select_port,
	output logic        over_range
);

	logic                valid_s1;
	tss_pkg::stage_t     stage_s1;
	logic                take;
	tss_pkg::digit_vec_t conv_digits;
	logic                conv_over;

	tss_scan_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.sample_valid   (sample_valid),
		.adc_sample     (adc_sample),
		.sample_stall   (sample_stall),
		.take           (take),
		.valid_s1       (valid_s1),
		.stage_s1       (stage_s1)
	);

	tss_convert u_conv (
		.sample (stage_s1.sample),
		.digits (conv_digits),
		.over   (conv_over)
	);

	tss_display u_disp (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1),
		.conv_digits  (conv_digits),
		.conv_over    (conv_over),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.segment_port (segment_port),
		.select_port  (select_port),
		.over_range   (over_range)
	);

endmodule

FILE: test/tss_scan_checker.sv
// Scoreboard for the temperature seven-segment scan block: predicts each result
// word from the accepted sample words and compares it with what the block sends.
// Depends on tss_pkg for the reset state and the digit types.
module tss_scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  logic [9:0]  adc_sample,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [7:0]  segment_port,
	input  logic [5:0]  select_port,
	input  logic        over_range,
	output int          words_waiting,
	output int          fail_count
);

	typedef struct packed {
		logic [7:0] segments;
		logic [5:0] selects;
		logic       flag;
	} scan_word_t;

	// g..a for digits 9 down to 0
	localparam logic [9:0][6:0] GLYPHS = {
		7'h67, 7'h7F, 7'h07, 7'h7C, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	logic [15:0]         interval;
	logic [15:0]         countdown;
	logic [3:0]          scan_sel;
	tss_pkg::digit_vec_t shown;
	logic                sticky_over;
	scan_word_t          pending_words [$];
	scan_word_t          want;
	int                  mismatches = 0;

	assign fail_count = mismatches;

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] need);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, need);
		mismatches++;
	endtask

	function automatic scan_word_t advance_scan(input logic [9:0] sample);
		logic [31:0] centi;
		logic [7:0]  pat;
		int          pos;
		scan_word_t  w;
		scan_sel = scan_sel[3] ? 4'b0001 : {scan_sel[2:0], 1'b0};
		if (countdown <= 16'd1) begin
			centi = (32'(sample) * 32'd50000) >> 10;
			if (centi > 32'd9999) begin
				centi = 32'd9999;
				sticky_over = 1'b1;
			end
			shown[0] = 4'((centi / 1000) % 10);
			shown[1] = 4'((centi / 100) % 10);
			shown[2] = 4'((centi / 10) % 10);
			shown[3] = 4'(centi % 10);
			countdown = interval;
		end else begin
			countdown = countdown - 16'd1;
		end
		pos = 0;
		for (int i = 0; i < tss_pkg::DIGITS; i++)
			if (scan_sel[i])
				pos = i;
		pat = {1'b0, GLYPHS[shown[pos]]};
		if (pos == int'(tss_pkg::DP_DIGIT))
			pat[7] = 1'b1;
		w.segments = {pat[5:0], 2'b00};
		w.selects = {~scan_sel, pat[7:6]};
		w.flag = sticky_over;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval = tss_pkg::RESET_INTERVAL;
			countdown = tss_pkg::RESET_INTERVAL;
			scan_sel = tss_pkg::SEL_RESET;
			shown = tss_pkg::RESET_DIGITS;
			sticky_over = 1'b0;
			pending_words.delete();
			words_waiting <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_words.size() == 0) begin
					report("result word with nothing pending", segment_port, 8'h00);
				end else begin
					want = pending_words.pop_front();
					if (segment_port !== want.segments)
						report("segment_port", segment_port, want.segments);
					if (select_port !== want.selects)
						report("select_port", 8'(select_port), 8'(want.selects));
					if (over_range !== want.flag)
						report("over_range", 8'(over_range), 8'(want.flag));
				end
			end
			if (cfg_write_en)
				interval = cfg_write_data;
			if (sample_valid && !sample_stall)
				pending_words.push_back(advance_scan(adc_sample));
			words_waiting <= pending_words.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Top of the scan block testbench: clock, reset, sample and result traffic,
// interval writes and the verdict. Depends on the block and tss_scan_checker,
// which both use tss_pkg.
module tb_top;

	localparam int QUIET_LIMIT = 1000;
	// per-phase read interval; slot 4 is replaced by a random value
	localparam logic [6:0][15:0] PHASE_INTERVAL = {
		16'd65535, 16'd40, 16'd0, 16'd7, 16'd3, 16'd2, 16'd0
	};
	localparam logic [19:0][9:0] EDGE_SAMPLES = {
		10'd0, 10'd1, 10'd2, 10'd20, 10'd21, 10'd41, 10'd100, 10'd128, 10'd200, 10'd203,
		10'd204, 10'd205, 10'd300, 10'd511, 10'd512, 10'd1023, 10'd341, 10'd682, 10'd1,
		10'd0
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_en;
	logic [15:0] cfg_write_data;
	logic        sample_valid;
	logic        sample_stall;
	logic [9:0]  adc_sample;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  segment_port;
	logic [5:0]  select_port;
	logic        over_range;
	int          words_waiting;
	int          fail_count;
	int          quiet_cycles = 0;
	bit          flood_on = 1'b0;
	bit          long_hold_done = 1'b0;

	always #6 clk = ~clk;

	temperature_seven_segment_scan dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.adc_sample    (adc_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.segment_port  (segment_port),
		.select_port   (select_port),
		.over_range    (over_range)
	);

	tss_scan_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.adc_sample    (adc_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.segment_port  (segment_port),
		.select_port   (select_port),
		.over_range    (over_range),
		.words_waiting (words_waiting),
		.fail_count    (fail_count)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly in range, some that saturate
	function automatic logic [9:0] scan_sample();
		if ($urandom_range(0, 9) < 7)
			return 10'($urandom_range(0, 204));
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic send_word(input logic [9:0] s, input int gap);
		sample_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (words_waiting != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_interval(input logic [15:0] v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// result side
	initial begin
		int open_left;
		int stall_left;
		open_left = 0;
		stall_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (flood_on && !long_hold_done) begin
				long_hold_done = 1'b1;
				open_left = 0;
				stall_left = 70;
			end else if (open_left == 0 && stall_left == 0) begin
				open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
				stall_left = pick_gap();
			end
			if (open_left > 0) begin
				result_stall <= 1'b0;
				open_left--;
			end else begin
				result_stall <= 1'b1;
				stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int n;
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		sample_valid <= 1'b0;
		adc_sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest interval; the reset countdown still runs out first
		set_interval(16'd1);
		for (int i = 0; i < 249; i++)
			send_word(10'($urandom_range(0, 204)), pick_gap());
		// every tick converts from here: digit values, saturation, then small values again
		for (int i = 19; i >= 0; i--)
			send_word(EDGE_SAMPLES[i], pick_gap());

		for (int p = 0; p < 7; p++) begin
			drain();
			set_interval(p == 4 ? 16'($urandom_range(1, 16)) : PHASE_INTERVAL[p]);
			flood_on = (p == 2);
			n = (p == 6) ? 30 : 80;
			for (int i = 0; i < n; i++)
				send_word(scan_sample(), flood_on ? 0 : pick_gap());
			flood_on = 1'b0;
		end
		drain();
		repeat (5) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
src/tss_pkg.sv
src/tss_scan_ctrl.sv
src/tss_convert.sv
src/tss_display.sv
src/temperature_seven_segment_scan.sv
test/tss_scan_checker.sv
test/tb_top.sv
